// ===== sv/aphc_pkg.sv =====
// Shared types and constants for the arm position hold controller.
`timescale 1ns / 1ps
`default_nettype none

package aphc_pkg;

  localparam int unsigned POS_W   = 12;
  localparam int unsigned ERR_W   = 13;
  localparam int unsigned DRIVE_W = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 8'sd127;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -8'sd127;
  localparam logic [7:0] TIMER_MAX = 8'd255;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POSITION      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POSITION      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ZONE         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DEADBAND     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SPEED        = 3'd7;

  // Register reset values
  localparam logic [11:0] RST_MIN_POSITION      = 12'd1300;
  localparam logic [11:0] RST_MAX_POSITION      = 12'd3000;
  localparam logic [9:0]  RST_SLOW_ZONE         = 10'd50;
  localparam logic [6:0]  RST_COMMAND_THRESHOLD = 7'd90;
  localparam logic [7:0]  RST_HOLD_DEADBAND     = 8'd10;
  localparam logic [6:0]  RST_SPEED_STEP        = 7'd5;
  localparam logic [7:0]  RST_UPDATE_PERIOD     = 8'd10;
  localparam logic [6:0]  RST_FULL_SPEED        = 7'd127;

  typedef enum logic [2:0] {
    ACT_IDLE     = 3'd0,
    ACT_LOWERING = 3'd1,
    ACT_RAISING  = 3'd2,
    ACT_HOLDING  = 3'd3,
    ACT_OVERRIDE = 3'd4
  } activity_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] command;
    logic [POS_W-1:0]          arm_position;
    logic [POS_W-1:0]          partner_position;
    logic                      manual_override;
  } in_item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic [2:0]                activity;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/arm_position_hold_controller.sv =====
// Top level of the arm position hold controller: control law, state and output skid.
`timescale 1ns / 1ps
`default_nettype none

// Arm position hold controller, one input item per control tick.
// Input channel (in_valid / in_stall / in_data): command, this arm's position,
// the partner arm's position and a manual override flag. Each accepted item
// yields exactly one result item (drive, activity) on the output channel
// (out_valid / out_stall / out_data).
// The result is registered into the output stage when the input item is accepted.
// Throughput: one item per cycle while in_stall is low; the whole control law for an item is
// evaluated in a single pass between the live state and the output register.
// A two-entry output stage (main register plus skid register) parts the
// channels: an item is still taken while a result waits under out_stall, and
// in_stall rises only once the skid register is occupied as well.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high and a write takes effect at the next edge. Write registers
// only while the block is idle.
// Reset (rst_n low, synchronous): registers return to their default limits,
// the hold state, drive level and tick timer clear, and both output entries
// are emptied.
module arm_position_hold_controller (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  aphc_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  wire                                out_stall,
  output aphc_pkg::out_item_t                out_data,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [aphc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [aphc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [11:0] min_position_r;
  logic [11:0] max_position_r;
  logic [9:0]  slow_zone_r;
  logic [6:0]  command_threshold_r;
  logic [7:0]  hold_deadband_r;
  logic [6:0]  speed_step_r;
  logic [7:0]  update_period_r;
  logic [6:0]  full_speed_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_position_r      <= aphc_pkg::RST_MIN_POSITION;
      max_position_r      <= aphc_pkg::RST_MAX_POSITION;
      slow_zone_r         <= aphc_pkg::RST_SLOW_ZONE;
      command_threshold_r <= aphc_pkg::RST_COMMAND_THRESHOLD;
      hold_deadband_r     <= aphc_pkg::RST_HOLD_DEADBAND;
      speed_step_r        <= aphc_pkg::RST_SPEED_STEP;
      update_period_r     <= aphc_pkg::RST_UPDATE_PERIOD;
      full_speed_r        <= aphc_pkg::RST_FULL_SPEED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aphc_pkg::CFG_MIN_POSITION:      min_position_r      <= cfg_data[11:0];
        aphc_pkg::CFG_MAX_POSITION:      max_position_r      <= cfg_data[11:0];
        aphc_pkg::CFG_SLOW_ZONE:         slow_zone_r         <= cfg_data[9:0];
        aphc_pkg::CFG_COMMAND_THRESHOLD: command_threshold_r <= cfg_data[6:0];
        aphc_pkg::CFG_HOLD_DEADBAND:     hold_deadband_r     <= cfg_data[7:0];
        aphc_pkg::CFG_SPEED_STEP:        speed_step_r        <= cfg_data[6:0];
        aphc_pkg::CFG_UPDATE_PERIOD:     update_period_r     <= cfg_data[7:0];
        aphc_pkg::CFG_FULL_SPEED:        full_speed_r        <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Output stage handshake
  // ---------------------------------------------------------------------
  logic                main_valid_r;
  logic                skid_valid_r;
  aphc_pkg::out_item_t main_data_r;
  aphc_pkg::out_item_t skid_data_r;
  logic                take;
  logic                acc;

  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;
  assign in_stall  = skid_valid_r;
  assign take      = main_valid_r && !out_stall;
  assign acc       = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------
  logic [11:0]        hold_target_r,    hold_target_nxt;
  logic signed [12:0] previous_error_r, previous_error_nxt;
  logic signed [7:0]  drive_level_r,    drive_level_nxt;
  logic               was_moving_r,     was_moving_nxt;
  logic               hold_armed_r,     hold_armed_nxt;
  logic [7:0]         period_timer_r,   period_timer_nxt;
  aphc_pkg::out_item_t result;

  // Control law, evaluated for the item at the input port
  logic [7:0]         timer_inc;
  logic signed [8:0]  cmd_ext;
  logic signed [8:0]  thr_ext;
  logic               lower_req;
  logic               raise_req;
  logic [12:0]        lo_plus_zone;
  logic [12:0]        pos_plus_zone;
  logic signed [7:0]  full_s;
  logic signed [7:0]  half_s;
  logic [12:0]        pos_sum;
  logic [11:0]        avg;
  logic [11:0]        target_clamped;
  logic signed [12:0] err;
  logic signed [13:0] err_ext;
  logic signed [13:0] band_ext;
  logic signed [9:0]  level_ext;
  logic signed [9:0]  step_ext;
  logic signed [9:0]  level_sum;
  logic signed [7:0]  level_sat;
  logic [11:0]        pos;

  assign pos = in_data.arm_position;

  always_comb begin
    hold_target_nxt    = hold_target_r;
    previous_error_nxt = previous_error_r;
    drive_level_nxt    = drive_level_r;
    was_moving_nxt     = was_moving_r;
    hold_armed_nxt     = hold_armed_r;
    period_timer_nxt   = period_timer_r;

    // Count the tick first, saturating at the top
    timer_inc = (period_timer_r == aphc_pkg::TIMER_MAX) ? period_timer_r
                                                        : period_timer_r + 8'd1;

    cmd_ext   = 9'(in_data.command);
    thr_ext   = $signed({2'b00, command_threshold_r});
    lower_req = (cmd_ext <= -thr_ext);
    raise_req = (cmd_ext >= thr_ext);

    // Slow-zone bounds kept without wrap by moving the zone to the other side
    lo_plus_zone  = {1'b0, min_position_r} + {3'b000, slow_zone_r};
    pos_plus_zone = {1'b0, pos} + {3'b000, slow_zone_r};
    full_s = $signed({1'b0, full_speed_r});
    half_s = $signed({2'b00, full_speed_r[6:1]});

    // Hold target: average of both positions, lower limit tested first
    pos_sum = {1'b0, pos} + {1'b0, in_data.partner_position};
    avg     = pos_sum[12:1];
    if (avg < min_position_r) begin
      target_clamped = min_position_r;
    end else if (avg > max_position_r) begin
      target_clamped = max_position_r;
    end else begin
      target_clamped = avg;
    end

    err      = $signed({1'b0, pos}) - $signed({1'b0, hold_target_r});
    err_ext  = 14'(err);
    band_ext = $signed({6'd0, hold_deadband_r});
    level_ext = 10'(drive_level_r);
    step_ext  = $signed({3'b000, speed_step_r});
    level_sum = level_ext;

    // Hold nudge, trend rules kept as specified including their odd signs
    if (err_ext < -band_ext) begin
      if (err < previous_error_r) begin
        if (pos < max_position_r) begin
          level_sum = level_ext + step_ext;
        end
      end else if (drive_level_r > 8'sd0) begin
        level_sum = level_ext - step_ext;
      end
    end else if (err_ext > band_ext) begin
      if (err > previous_error_r) begin
        if (pos > min_position_r) begin
          level_sum = level_ext - step_ext;
        end
      end else if (drive_level_r > 8'sd0) begin
        level_sum = level_ext + step_ext;
      end
    end

    if (level_sum > 10'(aphc_pkg::DRIVE_MAX)) begin
      level_sat = aphc_pkg::DRIVE_MAX;
    end else if (level_sum < 10'(aphc_pkg::DRIVE_MIN)) begin
      level_sat = aphc_pkg::DRIVE_MIN;
    end else begin
      level_sat = level_sum[7:0];
    end

    result.activity = aphc_pkg::ACT_IDLE;
    result.drive    = drive_level_r;

    if (in_data.manual_override) begin
      // Pass the command through; freeze all state
      result.activity = aphc_pkg::ACT_OVERRIDE;
      result.drive    = (in_data.command < aphc_pkg::DRIVE_MIN) ? aphc_pkg::DRIVE_MIN
                                                                : in_data.command;
    end else begin
      period_timer_nxt = timer_inc;
      if (lower_req) begin
        if (pos < min_position_r) begin
          drive_level_nxt = 8'sd0;
        end else if ({1'b0, pos} < lo_plus_zone) begin
          drive_level_nxt = -half_s;
        end else begin
          drive_level_nxt = -full_s;
        end
        was_moving_nxt  = 1'b1;
        result.activity = aphc_pkg::ACT_LOWERING;
      end else if (raise_req) begin
        if (pos > max_position_r) begin
          drive_level_nxt = 8'sd0;
        end else if (pos_plus_zone > {1'b0, max_position_r}) begin
          drive_level_nxt = half_s;
        end else begin
          drive_level_nxt = full_s;
        end
        was_moving_nxt  = 1'b1;
        result.activity = aphc_pkg::ACT_RAISING;
      end else if (was_moving_r) begin
        // Release: latch the target and start holding
        was_moving_nxt     = 1'b0;
        hold_target_nxt    = target_clamped;
        drive_level_nxt    = 8'sd0;
        period_timer_nxt   = 8'd0;
        hold_armed_nxt     = 1'b1;
        previous_error_nxt = $signed({1'b0, pos}) - $signed({1'b0, target_clamped});
        result.activity    = aphc_pkg::ACT_HOLDING;
      end else if (hold_armed_r) begin
        if (timer_inc > update_period_r) begin
          period_timer_nxt   = 8'd0;
          drive_level_nxt    = level_sat;
          previous_error_nxt = err;
        end
        result.activity = aphc_pkg::ACT_HOLDING;
      end
      result.drive = drive_level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_target_r    <= '0;
      previous_error_r <= '0;
      drive_level_r    <= '0;
      was_moving_r     <= 1'b0;
      hold_armed_r     <= 1'b0;
      period_timer_r   <= '0;
    end else if (acc) begin
      hold_target_r    <= hold_target_nxt;
      previous_error_r <= previous_error_nxt;
      drive_level_r    <= drive_level_nxt;
      was_moving_r     <= was_moving_nxt;
      hold_armed_r     <= hold_armed_nxt;
      period_timer_r   <= period_timer_nxt;
    end
  end

  // Output stage: fill main when it frees up, else park in skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (acc) begin
      if (!main_valid_r || take) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        main_data_r <= skid_data_r;
      end
    end else if (acc) begin
      if (!main_valid_r || take) begin
        main_data_r <= result;
      end else begin
        skid_data_r <= result;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held while main entry empty");

  a_override_freezes_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.manual_override) |=> $stable(period_timer_r) && $stable(drive_level_r))
    else $error("override item changed controller state");

  a_stalled_result_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && main_valid_r && out_stall) |=> skid_valid_r)
    else $error("item accepted under stall was not parked in skid");

  a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.drive != -8'sd128))
    else $error("drive left the saturation range");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the arm position hold controller: directed rows, then random phases.
`timescale 1ns / 1ps

module tb_top;
  import aphc_pkg::*;

  localparam int TOTAL_ITEMS = 1725;
  localparam int CALM_FROM   = 1575;
  localparam int PHASE_ITEMS = 200;
  localparam int CYCLE_LIMIT = 600000;

  // One row of the directed part: either a register write or an item, the
  // item optionally carrying a result typed in by hand.
  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              item;
    bit                    typed;
    logic signed [7:0]     drive;
    activity_t             act;
  } step_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  arm_position_hold_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the registers, starting from their reset values
  logic [11:0] lim_lo     = RST_MIN_POSITION;
  logic [11:0] lim_hi     = RST_MAX_POSITION;
  logic [9:0]  slow_cfg   = RST_SLOW_ZONE;
  logic [6:0]  cmd_thr    = RST_COMMAND_THRESHOLD;
  logic [7:0]  deadband   = RST_HOLD_DEADBAND;
  logic [6:0]  step_size  = RST_SPEED_STEP;
  logic [7:0]  period_cfg = RST_UPDATE_PERIOD;
  logic [6:0]  full_cfg   = RST_FULL_SPEED;

  // Shadow copy of the controller state, all clear after reset
  logic [11:0]        hold_tgt   = '0;
  logic signed [12:0] prev_err   = '0;
  logic signed [7:0]  drive_lvl  = '0;
  logic               moving     = 1'b0;
  logic               armed      = 1'b0;
  logic [7:0]         tick_count = '0;

  out_item_t awaited[$];
  int        items_sent     = 0;
  bit        calm           = 1'b0;
  int        sender_gap_pct = 10;
  int        mismatches     = 0;
  int        cycle_count    = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Give up well past the slowest correct run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic int clamp_pos(int v);
    return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
  endfunction

  function automatic int sat_level(int v);
    return (v > 127) ? 127 : ((v < -127) ? -127 : v);
  endfunction

  // Advance the shadow controller by one tick and return the drive it yields.
  function automatic out_item_t advance_controller(in_item_t it);
    int        cmd, pos, ptr, lo, hi, thr, full, half, band, stp, lvl, tgt, err, prev, zone;
    activity_t act;
    out_item_t r;
    cmd  = $signed(it.command);
    pos  = it.arm_position;
    ptr  = it.partner_position;
    lo   = lim_lo;
    hi   = lim_hi;
    zone = slow_cfg;
    thr  = cmd_thr;
    full = full_cfg;
    half = full / 2;
    band = deadband;
    stp  = step_size;
    // Override bypasses everything: no timer tick, no state change
    if (it.manual_override) begin
      r.drive    = (cmd < -127) ? DRIVE_MIN : it.command;
      r.activity = ACT_OVERRIDE;
      return r;
    end
    if (tick_count != TIMER_MAX) tick_count = tick_count + 8'd1;
    lvl = drive_lvl;
    // Lowering is tested first, so a zero threshold turns a zero command into a lower
    if (cmd <= -thr) begin
      if (pos < lo) lvl = 0;
      else if (pos < lo + zone) lvl = -half;
      else lvl = -full;
      moving = 1'b1;
      act = ACT_LOWERING;
    end else if (cmd >= thr) begin
      if (pos > hi) lvl = 0;
      else if (pos > hi - zone) lvl = half;
      else lvl = full;
      moving = 1'b1;
      act = ACT_RAISING;
    end else if (moving) begin
      // Release: lock the target onto the clamped average, lower limit first
      tgt = (pos + ptr) / 2;
      if (tgt < lo) tgt = lo;
      else if (tgt > hi) tgt = hi;
      moving     = 1'b0;
      hold_tgt   = 12'(tgt);
      lvl        = 0;
      tick_count = '0;
      armed      = 1'b1;
      prev_err   = 13'(pos - tgt);
      act = ACT_HOLDING;
    end else if (armed) begin
      if (int'(tick_count) > int'(period_cfg)) begin
        tgt  = hold_tgt;
        prev = prev_err;
        err  = pos - tgt;
        tick_count = '0;
        // Trend rules keep their odd signs on purpose
        if (err < -band) begin
          if (err < prev) begin
            if (pos < hi) lvl += stp;
          end else if (lvl > 0) lvl -= stp;
        end else if (err > band) begin
          if (err > prev) begin
            if (pos > lo) lvl -= stp;
          end else if (lvl > 0) lvl += stp;
        end
        lvl = sat_level(lvl);
        prev_err = 13'(err);
      end
      act = ACT_HOLDING;
    end else begin
      act = ACT_IDLE;
    end
    drive_lvl  = 8'(lvl);
    r.drive    = 8'(lvl);
    r.activity = act;
    return r;
  endfunction

  // Compare every accepted result item with the oldest one awaited.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        $error("unawaited result item: drive %0d activity %0d",
               $signed(out_data.drive), out_data.activity);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        if (out_data.drive !== want.drive) begin
          $error("drive: expected %0d, got %0d", $signed(want.drive), $signed(out_data.drive));
          mismatches++;
        end
        if (out_data.activity !== want.activity) begin
          $error("activity: expected %0d, got %0d", want.activity, out_data.activity);
          mismatches++;
        end
      end
    end
  end

  // Stall the result channel in bursts, with quiet spans and none at the tail.
  initial begin : result_stall
    int left, mode, span;
    left = 0;
    mode = 0;
    span = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(50, 400);
      end
      span--;
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= 1'b0;
        if (!calm && mode != 0 && $urandom_range(0, 99) < ((mode == 1) ? 5 : 25))
          left = $urandom_range(1, 19);
      end
    end
  end

  // Offer one item, hold it until taken, and queue what it should produce.
  // Called and returns at a falling edge.
  task automatic send_item(in_item_t it, bit typed, out_item_t fixed);
    out_item_t want;
    if (!calm && $urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    want = advance_controller(it);
    awaited.push_back(typed ? fixed : want);
    items_sent++;
    calm = (items_sent >= CALM_FROM);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every awaited result has come back.
  task automatic settle_outputs();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_POSITION:      lim_lo     = val[11:0];
      CFG_MAX_POSITION:      lim_hi     = val[11:0];
      CFG_SLOW_ZONE:         slow_cfg   = val[9:0];
      CFG_COMMAND_THRESHOLD: cmd_thr    = val[6:0];
      CFG_HOLD_DEADBAND:     deadband   = val[7:0];
      CFG_SPEED_STEP:        step_size  = val[6:0];
      CFG_UPDATE_PERIOD:     period_cfg = val[7:0];
      CFG_FULL_SPEED:        full_cfg   = val[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Write all eight registers: two extreme sets first, then random ones.
  task automatic apply_settings(int phase);
    logic [11:0] lo, hi, sz, th, db, st, pd, fs;
    case (phase)
      0: begin
        lo = 12'd0; hi = 12'd4095; sz = 12'd1023; th = 12'd127;
        db = 12'd255; st = 12'd127; pd = 12'd255; fs = 12'd127;
      end
      1: begin
        lo = 12'd0; hi = 12'd4095; sz = 12'd0; th = 12'd1;
        db = 12'd0; st = 12'd127; pd = 12'd0; fs = 12'd0;
      end
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          // Any data word, upper bits of the narrow registers included
          lo = 12'($urandom); hi = 12'($urandom); sz = 12'($urandom); th = 12'($urandom);
          db = 12'($urandom); st = 12'($urandom); pd = 12'($urandom); fs = 12'($urandom);
        end else begin
          lo = 12'($urandom_range(200, 1500));
          hi = 12'($urandom_range(2500, 3900));
          sz = 12'($urandom_range(0, 300));
          th = 12'($urandom_range(1, 126));
          db = 12'($urandom_range(0, 60));
          st = 12'($urandom_range(0, 40));
          pd = 12'($urandom_range(0, 8));
          fs = 12'($urandom_range(0, 127));
        end
      end
    endcase
    case ($urandom_range(0, 3))
      0: sender_gap_pct = 0;
      1: sender_gap_pct = 3;
      2: sender_gap_pct = 12;
      default: sender_gap_pct = 35;
    endcase
    write_reg(CFG_MIN_POSITION, lo);
    write_reg(CFG_MAX_POSITION, hi);
    write_reg(CFG_SLOW_ZONE, sz);
    write_reg(CFG_COMMAND_THRESHOLD, th);
    write_reg(CFG_HOLD_DEADBAND, db);
    write_reg(CFG_SPEED_STEP, st);
    write_reg(CFG_UPDATE_PERIOD, pd);
    write_reg(CFG_FULL_SPEED, fs);
  endtask

  function automatic logic signed [7:0] move_command(bit lower);
    int m;
    m = $urandom_range(int'(cmd_thr), 127);
    if (lower && $urandom_range(0, 9) == 0) return 8'h80;
    return lower ? 8'(-m) : 8'(m);
  endfunction

  // A command inside the threshold; with a zero threshold there is none, so send zero
  function automatic logic signed [7:0] rest_command();
    int m;
    if (cmd_thr == 0) return 8'sd0;
    m = $urandom_range(0, int'(cmd_thr) - 1);
    return ($urandom_range(0, 1) != 0) ? 8'(-m) : 8'(m);
  endfunction

  // Favour positions around the limits and their slow zones
  function automatic logic [11:0] pick_position();
    int lo, hi, r;
    lo = lim_lo;
    hi = lim_hi;
    r  = int'(slow_cfg) + 30;
    case ($urandom_range(0, 3))
      0: return 12'($urandom);
      1: return 12'(clamp_pos(lo + int'($urandom_range(0, 2 * r)) - r));
      2: return 12'(clamp_pos(hi + int'($urandom_range(0, 2 * r)) - r));
      default: return 12'(clamp_pos((lo + hi) / 2 + int'($urandom_range(0, 400)) - 200));
    endcase
  endfunction

  // Mostly a move, a release and a hold stretch drifting round the target;
  // otherwise a short burst of arbitrary items.
  task automatic run_episode();
    in_item_t it;
    int       n, off, base, reach, p;
    bit       lower;
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 5)) begin
        it.command          = 8'($urandom);
        it.arm_position     = 12'($urandom);
        it.partner_position = 12'($urandom);
        it.manual_override  = ($urandom_range(0, 3) == 0);
        send_item(it, 1'b0, '0);
      end
    end else begin
      lower = $urandom_range(0, 1);
      repeat ($urandom_range(1, 6)) begin
        it.manual_override  = ($urandom_range(0, 15) == 0);
        it.command          = move_command(lower);
        it.arm_position     = pick_position();
        it.partner_position = 12'(clamp_pos(int'(it.arm_position) +
                                            int'($urandom_range(0, 400)) - 200));
        send_item(it, 1'b0, '0);
      end
      it.manual_override  = 1'b0;
      it.command          = rest_command();
      it.arm_position     = pick_position();
      it.partner_position = 12'(clamp_pos(int'(it.arm_position) +
                                          int'($urandom_range(0, 400)) - 200));
      send_item(it, 1'b0, '0);
      // Hold long enough to see several updates when the period is short
      base  = hold_tgt;
      reach = int'(deadband) + 40;
      off   = int'($urandom_range(0, 2 * reach)) - reach;
      p     = period_cfg;
      n     = $urandom_range(1, (p < 12) ? 4 * (p + 1) + 4 : 40);
      repeat (n) begin
        it.manual_override  = ($urandom_range(0, 11) == 0);
        it.command          = it.manual_override ? 8'($urandom) : rest_command();
        it.arm_position     = 12'(clamp_pos(base + off));
        it.partner_position = 12'($urandom);
        send_item(it, 1'b0, '0);
        off += int'($urandom_range(0, 30)) - 15;
        if ($urandom_range(0, 15) == 0) off = -off;
      end
    end
  endtask

  function automatic step_row_t item_row(logic signed [7:0] cmd, logic [11:0] pos,
                                         logic [11:0] ptr, bit ovr, bit typed,
                                         logic signed [7:0] drv, activity_t act);
    step_row_t r;
    r.is_write                = 1'b0;
    r.reg_idx                 = '0;
    r.reg_val                 = '0;
    r.item.command            = cmd;
    r.item.arm_position       = pos;
    r.item.partner_position   = ptr;
    r.item.manual_override    = ovr;
    r.typed                   = typed;
    r.drive                   = drv;
    r.act                     = act;
    return r;
  endfunction

  function automatic step_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    step_row_t r;
    r         = item_row(8'sd0, 12'd0, 12'd0, 1'b0, 1'b0, 8'sd0, ACT_IDLE);
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.reg_val  = val;
    return r;
  endfunction

  initial begin : stimulus
    step_row_t rows[$];
    out_item_t fixed;
    int        phase, phase_end;

    // Reset values: limits 1300..3000, slow zone 50, threshold 90, period 10
    rows.push_back(item_row(8'sd0, 12'd2000, 12'd2000, 1'b0, 1'b1, 8'sd0, ACT_IDLE));
    rows.push_back(item_row(8'sd127, 12'd2000, 12'd0, 1'b1, 1'b1, DRIVE_MAX, ACT_OVERRIDE));
    // Override with the most negative command clamps to -127
    rows.push_back(item_row(8'h80, 12'd4095, 12'd4095, 1'b1, 1'b1, DRIVE_MIN, ACT_OVERRIDE));
    rows.push_back(item_row(-8'sd90, 12'd2000, 12'd2000, 1'b0, 1'b1, DRIVE_MIN, ACT_LOWERING));
    rows.push_back(item_row(8'h80, 12'd1320, 12'd2000, 1'b0, 1'b1, -8'sd63, ACT_LOWERING));
    rows.push_back(item_row(-8'sd100, 12'd0, 12'd2000, 1'b0, 1'b1, 8'sd0, ACT_LOWERING));
    rows.push_back(item_row(8'sd90, 12'd2000, 12'd2000, 1'b0, 1'b1, DRIVE_MAX, ACT_RAISING));
    rows.push_back(item_row(8'sd127, 12'd2990, 12'd2000, 1'b0, 1'b1, 8'sd63, ACT_RAISING));
    rows.push_back(item_row(8'sd100, 12'd4095, 12'd2000, 1'b0, 1'b1, 8'sd0, ACT_RAISING));
    rows.push_back(item_row(8'sd89, 12'd2000, 12'd2100, 1'b0, 1'b1, 8'sd0, ACT_HOLDING));
    rows.push_back(item_row(-8'sd89, 12'd2000, 12'd2100, 1'b1, 1'b1, -8'sd89, ACT_OVERRIDE));
    rows.push_back(item_row(8'sd0, 12'd2000, 12'd2000, 1'b0, 1'b0, 8'sd0, ACT_IDLE));
    // Crossed limits, zero period, zero slow zone, full speed of 1
    rows.push_back(reg_row(CFG_UPDATE_PERIOD, 12'd0));
    rows.push_back(reg_row(CFG_SPEED_STEP, 12'd127));
    rows.push_back(reg_row(CFG_HOLD_DEADBAND, 12'd0));
    rows.push_back(reg_row(CFG_MIN_POSITION, 12'd3000));
    rows.push_back(reg_row(CFG_MAX_POSITION, 12'd1000));
    rows.push_back(reg_row(CFG_SLOW_ZONE, 12'd0));
    rows.push_back(reg_row(CFG_FULL_SPEED, 12'd1));
    rows.push_back(reg_row(CFG_COMMAND_THRESHOLD, 12'd1));
    rows.push_back(item_row(-8'sd1, 12'd3500, 12'd2000, 1'b0, 1'b1, -8'sd1, ACT_LOWERING));
    // Release with the average under the lower limit and over the upper one:
    // the lower limit is tested first and wins
    rows.push_back(item_row(8'sd0, 12'd2000, 12'd2000, 1'b0, 1'b1, 8'sd0, ACT_HOLDING));
    rows.push_back(item_row(8'sd0, 12'd2500, 12'd0, 1'b0, 1'b0, 8'sd0, ACT_IDLE));
    rows.push_back(item_row(8'sd0, 12'd100, 12'd0, 1'b0, 1'b0, 8'sd0, ACT_IDLE));
    rows.push_back(item_row(8'sd0, 12'd100, 12'd0, 1'b0, 1'b0, 8'sd0, ACT_IDLE));
    rows.push_back(item_row(8'sd0, 12'd4000, 12'd0, 1'b0, 1'b0, 8'sd0, ACT_IDLE));
    rows.push_back(item_row(8'sd0, 12'd4000, 12'd0, 1'b0, 1'b0, 8'sd0, ACT_IDLE));
    // Zero threshold: a zero command lowers
    rows.push_back(reg_row(CFG_COMMAND_THRESHOLD, 12'd0));
    rows.push_back(item_row(8'sd0, 12'd4095, 12'd0, 1'b0, 1'b1, -8'sd1, ACT_LOWERING));
    // Largest period: the saturated timer never exceeds it
    rows.push_back(reg_row(CFG_UPDATE_PERIOD, 12'd255));
    rows.push_back(reg_row(CFG_COMMAND_THRESHOLD, 12'd127));
    rows.push_back(item_row(8'sd126, 12'd2000, 12'd2000, 1'b0, 1'b1, 8'sd0, ACT_HOLDING));
    rows.push_back(item_row(-8'sd126, 12'd0, 12'd4095, 1'b0, 1'b0, 8'sd0, ACT_IDLE));
    rows.push_back(item_row(8'sd127, 12'd4095, 12'd0, 1'b0, 1'b1, 8'sd0, ACT_RAISING));

    // Keep reset low, then release it at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_write) begin
        settle_outputs();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        fixed.drive    = rows[i].drive;
        fixed.activity = rows[i].act;
        send_item(rows[i].item, rows[i].typed, fixed);
      end
    end

    // Random phases, each opened by draining the block and rewriting every register
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      settle_outputs();
      apply_settings(phase);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < TOTAL_ITEMS) run_episode();
      phase++;
    end

    settle_outputs();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
